// File: hdl/single_wire_backlight_dimming_core_assert.svh
// Assertion shorthands for the dimming core checker.
// Every check is sampled on clk_i and is off while rst_ni is low.
`ifndef SINGLE_WIRE_BACKLIGHT_DIMMING_CORE_ASSERT_SVH
`define SINGLE_WIRE_BACKLIGHT_DIMMING_CORE_ASSERT_SVH

// Plain concurrent check.
`define SWBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that fires in the cycle after the trigger condition.
`define SWBD_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// File: hdl/swbd_pkg.sv
`timescale 1ns / 1ps
package swbd_pkg;

  // Sizes
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int CODE_BITS       = 8;
  localparam int LEVEL_W         = 8;
  localparam int ENTRY_IDX_W     = 5;
  localparam int DUR_W           = 12;
  localparam int LEN_REG_W       = 6;
  localparam int TBL_ADDR_W      = 8;
  localparam int SEG_CNT_W       = 6;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  // Segment durations in microseconds
  localparam logic [DUR_W-1:0] T_EOS       = 12'd300;
  localparam logic [DUR_W-1:0] T_DET_DELAY = 12'd150;
  localparam logic [DUR_W-1:0] T_DET_TIME  = 12'd500;
  localparam logic [DUR_W-1:0] T_WINDOW    = 12'd3500;
  localparam logic [DUR_W-1:0] T_START     = 12'd10;
  localparam logic [DUR_W-1:0] T_SHORT     = 12'd180;
  localparam logic [DUR_W-1:0] T_LONG      = 12'd400;
  localparam logic [DUR_W-1:0] T_OFF       = 12'd3000;
  localparam logic [DUR_W-1:0] T_HOLD      = 12'd0;

  // Positions in the 40-segment frame
  localparam logic [SEG_CNT_W-1:0] SEG_PRE_EOS    = 6'd0;
  localparam logic [SEG_CNT_W-1:0] SEG_DET_DELAY  = 6'd1;
  localparam logic [SEG_CNT_W-1:0] SEG_DET_TIME   = 6'd2;
  localparam logic [SEG_CNT_W-1:0] SEG_WINDOW     = 6'd3;
  localparam logic [SEG_CNT_W-1:0] SEG_ADDR_FIRST = 6'd4;
  localparam logic [SEG_CNT_W-1:0] SEG_ADDR_EOS   = 6'd20;
  localparam logic [SEG_CNT_W-1:0] SEG_START      = 6'd21;
  localparam logic [SEG_CNT_W-1:0] SEG_CODE_FIRST = 6'd22;
  localparam logic [SEG_CNT_W-1:0] SEG_TAIL_EOS   = 6'd38;
  localparam logic [SEG_CNT_W-1:0] SEG_LAST       = 6'd39;

  typedef enum logic {
    REQ_LEVEL = 1'b0,
    REQ_TABLE = 1'b1
  } req_type_e;

  typedef enum logic {
    REG_DEVICE_ADDRESS = 1'b0,
    REG_TABLE_LENGTH   = 1'b1
  } reg_idx_e;

  // Table write port
  typedef struct packed {
    logic                  en;
    logic [TBL_ADDR_W-1:0] addr;
    logic [LEVEL_W-1:0]    thr;
    logic [CODE_BITS-1:0]  code;
  } tbl_wr_t;

  // One line segment
  typedef struct packed {
    logic             line_level;
    logic [DUR_W-1:0] duration_us;
    logic             last;
  } seg_t;

  // Half of a data bit: a one is short low / long high, a zero the reverse
  function automatic seg_t bit_seg(logic b, logic phase);
    seg_t s;
    s.last        = 1'b0;
    s.line_level  = phase;
    if (phase == 1'b0) begin
      s.duration_us = b ? T_SHORT : T_LONG;
    end else begin
      s.duration_us = b ? T_LONG : T_SHORT;
    end
    return s;
  endfunction

  // Segment at frame position cnt, bytes sent LSB first
  function automatic seg_t seg_lookup(logic [SEG_CNT_W-1:0] cnt,
                                      logic [7:0] addr_byte,
                                      logic [CODE_BITS-1:0] code_byte);
    logic [SEG_CNT_W-1:0] rel;
    seg_t                 s;
    rel = '0;
    s   = '{line_level: 1'b1, duration_us: T_HOLD, last: 1'b1};
    if (cnt >= SEG_CODE_FIRST && cnt < SEG_TAIL_EOS) begin
      rel = cnt - SEG_CODE_FIRST;
      s   = bit_seg(code_byte[rel[3:1]], rel[0]);
    end else if (cnt >= SEG_ADDR_FIRST && cnt < SEG_ADDR_EOS) begin
      rel = cnt - SEG_ADDR_FIRST;
      s   = bit_seg(addr_byte[rel[3:1]], rel[0]);
    end else begin
      unique case (cnt)
        SEG_PRE_EOS:   s = '{line_level: 1'b0, duration_us: T_EOS,       last: 1'b0};
        SEG_DET_DELAY: s = '{line_level: 1'b1, duration_us: T_DET_DELAY, last: 1'b0};
        SEG_DET_TIME:  s = '{line_level: 1'b0, duration_us: T_DET_TIME,  last: 1'b0};
        SEG_WINDOW:    s = '{line_level: 1'b1, duration_us: T_WINDOW,    last: 1'b0};
        SEG_ADDR_EOS:  s = '{line_level: 1'b0, duration_us: T_EOS,       last: 1'b0};
        SEG_START:     s = '{line_level: 1'b1, duration_us: T_START,     last: 1'b0};
        SEG_TAIL_EOS:  s = '{line_level: 1'b0, duration_us: T_EOS,       last: 1'b0};
        default:       s = '{line_level: 1'b1, duration_us: T_HOLD,      last: 1'b1};
      endcase
    end
    return s;
  endfunction

endpackage

// File: hdl/swbd_if.sv
`timescale 1ns / 1ps
// Request channel
interface swbd_in_if;
  import swbd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [LEVEL_W-1:0]     level;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [LEVEL_W-1:0]     entry_threshold;
  logic [CODE_BITS-1:0]   entry_code;

  modport source (output valid, req_type, level, entry_index, entry_threshold, entry_code,
                  input ready);
  modport sink   (input valid, req_type, level, entry_index, entry_threshold, entry_code,
                  output ready);
endinterface

// Line segment channel
interface swbd_out_if;
  import swbd_pkg::*;
  logic             valid;
  logic             ready;
  logic             line_level;
  logic [DUR_W-1:0] duration_us;
  logic             last;

  modport source (output valid, line_level, duration_us, last, input ready);
  modport sink   (input valid, line_level, duration_us, last, output ready);
endinterface

// File: hdl/swbd_table.sv
`timescale 1ns / 1ps
// Threshold/code table: one write port, one registered read port
module swbd_table
  import swbd_pkg::*;
#(
  parameter int  DEPTH = TABLE_DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  tbl_wr_t              wr_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output logic [LEVEL_W-1:0]   rd_thr_o,
  output logic [CODE_BITS-1:0] rd_code_o
);

  logic [LEVEL_W+CODE_BITS-1:0] mem [DEPTH];
  logic [LEVEL_W+CODE_BITS-1:0] rd_q;

  // write
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[IDX_W-1:0]] <= {wr_i.thr, wr_i.code};
    end
  end

  // read, registered
  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  assign rd_thr_o  = rd_q[LEVEL_W+CODE_BITS-1:CODE_BITS];
  assign rd_code_o = rd_q[CODE_BITS-1:0];

endmodule

// File: hdl/single_wire_backlight_dimming_core.sv
`timescale 1ns / 1ps
// Single-wire backlight dimming sequencer. Table-write words store a
// threshold/code pair. A level-0 request yields one word (low, 3000 us,
// last). Any other level scans the table RAM one entry per cycle through its
// registered read port; if the chosen entry differs from the one last sent,
// 40 segment words follow, one per cycle while the sink is ready, through a
// one-word output register. One request is in work at a time; a new word is
// taken only when idle, once the scan has ended or the last segment of the
// previous one has been loaded.
module single_wire_backlight_dimming_core
  import swbd_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  swbd_in_if.sink               in_i,
  swbd_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int          IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [8:0]  DEPTH_V = 9'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [LEVEL_W-1:0]   level_q, level_d;
  logic [IDX_W-1:0]     last_idx_q, last_idx_d;
  logic [IDX_W-1:0]     issue_q, issue_d;
  logic                 cmp_v_q, cmp_v_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]     sel_q, sel_d;
  logic [CODE_BITS-1:0] code_q, code_d;
  logic                 off_q, off_d;
  logic [SEG_CNT_W-1:0] seg_cnt_q, seg_cnt_d;
  logic [IDX_W-1:0]     cur_idx_q, cur_idx_d;
  logic                 known_q, known_d;
  logic                 out_valid_q, out_valid_d;
  seg_t                 out_q, out_d;

  logic [7:0]           dev_addr_q;
  logic [LEN_REG_W-1:0] tbl_len_q;

  tbl_wr_t              tbl_wr;
  logic [LEVEL_W-1:0]   rd_thr;
  logic [CODE_BITS-1:0] rd_code;
  logic                 in_acc;
  logic                 decide;
  logic                 load;
  logic [IDX_W-1:0]     len_last;
  seg_t                 seg_next;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
      tbl_len_q  <= LEN_REG_W'(1);
    end else if (psel && penable && pwrite) begin
      if (reg_idx_e'(paddr[2]) == REG_DEVICE_ADDRESS) begin
        dev_addr_q <= pwdata[7:0];
      end else begin
        tbl_len_q <= pwdata[LEN_REG_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx_e'(paddr[2]) == REG_DEVICE_ADDRESS) begin
      prdata = {{(APB_DATA_W-8){1'b0}}, dev_addr_q};
    end else begin
      prdata = {{(APB_DATA_W-LEN_REG_W){1'b0}}, tbl_len_q};
    end
  end

  // last searched entry: length clamped to 1..depth
  always_comb begin
    if (tbl_len_q == '0) begin
      len_last = '0;
    end else if ({3'b000, tbl_len_q} > DEPTH_V) begin
      len_last = IDX_MAX;
    end else begin
      len_last = IDX_W'(tbl_len_q - LEN_REG_W'(1));
    end
  end

  // table memory
  assign in_acc = in_i.valid && in_i.ready;

  always_comb begin
    tbl_wr.en   = in_acc && (req_type_e'(in_i.req_type) == REQ_TABLE)
                  && ({4'b0000, in_i.entry_index} < DEPTH_V);
    tbl_wr.addr = TBL_ADDR_W'(in_i.entry_index);
    tbl_wr.thr  = in_i.entry_threshold;
    tbl_wr.code = in_i.entry_code;
  end

  swbd_table #(
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (issue_q),
    .rd_thr_o  (rd_thr),
    .rd_code_o (rd_code)
  );

  // scan result: first hit, or the last entry
  assign decide = (state_q == ST_SEARCH) && cmp_v_q
                  && ((level_q <= rd_thr) || (cmp_idx_q == last_idx_q));

  assign load     = !out_valid_q || out_o.ready;
  assign seg_next = seg_lookup(seg_cnt_q, dev_addr_q, code_q);
  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    last_idx_d  = last_idx_q;
    issue_d     = issue_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = issue_q;
    sel_d       = sel_q;
    code_d      = code_q;
    off_d       = off_q;
    seg_cnt_d   = seg_cnt_q;
    cur_idx_d   = cur_idx_q;
    known_d     = known_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && req_type_e'(in_i.req_type) == REQ_LEVEL) begin
          if (in_i.level == '0) begin
            off_d   = 1'b1;
            sel_d   = '0;
            state_d = ST_EMIT;
          end else begin
            level_d    = in_i.level;
            last_idx_d = len_last;
            issue_d    = '0;
            state_d    = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmp_v_d = 1'b1;
        if (issue_q != last_idx_q) begin
          issue_d = issue_q + IDX_W'(1);
        end
        if (decide) begin
          cmp_v_d = 1'b0;
          if (known_q && cur_idx_q == cmp_idx_q) begin
            state_d = ST_IDLE;
          end else begin
            sel_d     = cmp_idx_q;
            code_d    = rd_code;
            off_d     = 1'b0;
            seg_cnt_d = '0;
            state_d   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (off_q) begin
            out_d = '{line_level: 1'b0, duration_us: T_OFF, last: 1'b1};
          end else begin
            out_d = seg_next;
          end
          if (off_q || seg_cnt_q == SEG_LAST) begin
            cur_idx_d = sel_q;
            known_d   = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            seg_cnt_d = seg_cnt_q + SEG_CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_v_q     <= 1'b0;
      cur_idx_q   <= '0;
      known_q     <= 1'b0;
      out_valid_q <= 1'b0;
      seg_cnt_q   <= '0;
      off_q       <= 1'b0;
      issue_q     <= '0;
    end else begin
      state_q     <= state_d;
      cmp_v_q     <= cmp_v_d;
      cur_idx_q   <= cur_idx_d;
      known_q     <= known_d;
      out_valid_q <= out_valid_d;
      seg_cnt_q   <= seg_cnt_d;
      off_q       <= off_d;
      issue_q     <= issue_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    level_q    <= level_d;
    last_idx_q <= last_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    sel_q      <= sel_d;
    code_q     <= code_d;
    out_q      <= out_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.line_level  = out_q.line_level;
  assign out_o.duration_us = out_q.duration_us;
  assign out_o.last        = out_q.last;

endmodule

// File: hdl/swbd_checker.sv
`timescale 1ns / 1ps
`include "single_wire_backlight_dimming_core_assert.svh"
// Port-level checks on the segment channel
module swbd_checker
  import swbd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_line_level,
  input logic [DUR_W-1:0] out_duration_us,
  input logic             out_last
);

  // a stalled word stays put
  `SWBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "segment word dropped while stalled")
  `SWBD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_duration_us) && $stable(out_line_level) && $stable(out_last), "segment word changed while stalled")

  // a run ends either in the off segment or in the indefinite high hold
  `SWBD_ASSERT(a_last_form, !(out_valid && out_last) || (out_line_level && out_duration_us == T_HOLD) || (!out_line_level && out_duration_us == T_OFF), "last word is neither off nor hold")

  // only the final hold has zero length
  `SWBD_ASSERT(a_zero_is_last, !(out_valid && out_duration_us == T_HOLD) || (out_last && out_line_level), "zero-length segment before end of run")

endmodule

bind single_wire_backlight_dimming_core swbd_checker u_swbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_line_level  (out_o.line_level),
  .out_duration_us (out_o.duration_us),
  .out_last        (out_o.last)
);

// File: dv/swbd_line_checker.sv
`timescale 1ns / 1ps
// Watches the request, segment and register ports of the dimming core, keeps its own
// copy of the table and registers, and compares every segment word with the oldest
// predicted one.
module swbd_line_checker
  import swbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  swbd_in_if                    req_mon,
  swbd_out_if                   seg_mon,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  input  logic [APB_DATA_W-1:0] prdata_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    words_checked_o,
  output int                    frames_o
);

  localparam int DEPTH      = TABLE_DEPTH_DEF;
  localparam int PRINT_CAP  = 50;

  // Shadow table and registers
  logic [LEVEL_W-1:0]     thr_mem  [DEPTH];
  logic [CODE_BITS-1:0]   code_mem [DEPTH];
  logic [ENTRY_IDX_W-1:0] sent_idx;
  logic                   sent_known;
  logic [7:0]             dev_addr;
  logic [LEN_REG_W-1:0]   len_reg;

  // Segment words still owed by the core, oldest first
  seg_t pending_segs[$];

  int fails         = 0;
  int words_checked = 0;
  int frames        = 0;
  int pending_cnt   = 0;

  assign fail_count_o    = fails;
  assign pending_o       = pending_cnt;
  assign words_checked_o = words_checked;
  assign frames_o        = frames;

  task automatic report_mismatch(input string what);
    fails++;
    if (fails <= PRINT_CAP) $display("[%0t] line check: %s", $time, what);
  endtask

  task automatic queue_seg(input logic lvl, input logic [DUR_W-1:0] dur, input logic fin);
    seg_t s;
    s.line_level  = lvl;
    s.duration_us = dur;
    s.last        = fin;
    pending_segs.push_back(s);
  endtask

  // One byte, LSB first; a one is short low then long high
  task automatic queue_byte(input logic [7:0] value);
    for (int b = 0; b < 8; b++) begin
      if (value[b]) begin
        queue_seg(1'b0, T_SHORT, 1'b0);
        queue_seg(1'b1, T_LONG, 1'b0);
      end else begin
        queue_seg(1'b0, T_LONG, 1'b0);
        queue_seg(1'b1, T_SHORT, 1'b0);
      end
    end
  endtask

  // Update the shadow state for one request word and queue the segments it causes
  task automatic plan_line_segments(input logic rt, input logic [LEVEL_W-1:0] lvl,
                                    input logic [ENTRY_IDX_W-1:0] idx,
                                    input logic [LEVEL_W-1:0] thr,
                                    input logic [CODE_BITS-1:0] code);
    int len;
    int pick;
    bit found;
    if (rt == REQ_TABLE) begin
      thr_mem[idx]  = thr;
      code_mem[idx] = code;
    end else if (lvl == '0) begin
      // off: a single low segment, entry 0 counts as sent
      sent_idx   = '0;
      sent_known = 1'b1;
      queue_seg(1'b0, T_OFF, 1'b1);
    end else begin
      len = int'(len_reg);
      if (len < 1) len = 1;
      if (len > DEPTH) len = DEPTH;
      // first entry whose threshold covers the level, else the last one searched
      pick  = len - 1;
      found = 1'b0;
      for (int i = 0; i < len; i++) begin
        if (!found && lvl <= thr_mem[i]) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (!(sent_known && int'(sent_idx) == pick)) begin
        queue_seg(1'b0, T_EOS, 1'b0);
        queue_seg(1'b1, T_DET_DELAY, 1'b0);
        queue_seg(1'b0, T_DET_TIME, 1'b0);
        queue_seg(1'b1, T_WINDOW, 1'b0);
        queue_byte(dev_addr);
        queue_seg(1'b0, T_EOS, 1'b0);
        queue_seg(1'b1, T_START, 1'b0);
        queue_byte(code_mem[pick]);
        queue_seg(1'b0, T_EOS, 1'b0);
        queue_seg(1'b1, T_HOLD, 1'b1);
        sent_idx   = ENTRY_IDX_W'(pick);
        sent_known = 1'b1;
        frames++;
      end
    end
  endtask

  task automatic check_segment();
    seg_t want;
    if (pending_segs.size() == 0) begin
      report_mismatch($sformatf("unexpected segment word level %0b dur %0d last %0b",
                                seg_mon.line_level, seg_mon.duration_us, seg_mon.last));
    end else begin
      want = pending_segs.pop_front();
      words_checked++;
      if (seg_mon.line_level !== want.line_level)
        report_mismatch($sformatf("line_level %0b, want %0b",
                                  seg_mon.line_level, want.line_level));
      if (seg_mon.duration_us !== want.duration_us)
        report_mismatch($sformatf("duration_us %0d, want %0d",
                                  seg_mon.duration_us, want.duration_us));
      if (seg_mon.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", seg_mon.last, want.last));
    end
  endtask

  // Register writes update the shadow copy, reads are compared against it
  task automatic track_register();
    if (pwrite_i) begin
      case (paddr_i[APB_ADDR_W-1:2])
        REG_DEVICE_ADDRESS: dev_addr = pwdata_i[7:0];
        REG_TABLE_LENGTH:   len_reg  = pwdata_i[LEN_REG_W-1:0];
        default: ;
      endcase
    end else begin
      case (paddr_i[APB_ADDR_W-1:2])
        REG_DEVICE_ADDRESS:
          if (prdata_i[7:0] !== dev_addr)
            report_mismatch($sformatf("device_address reads %0h, want %0h",
                                      prdata_i[7:0], dev_addr));
        REG_TABLE_LENGTH:
          if (prdata_i[LEN_REG_W-1:0] !== len_reg)
            report_mismatch($sformatf("table_length reads %0d, want %0d",
                                      prdata_i[LEN_REG_W-1:0], len_reg));
        default: ;
      endcase
    end
  endtask

  // Segment words are matched before the request word of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_idx   = '0;
      sent_known = 1'b0;
      dev_addr   = '0;
      len_reg    = LEN_REG_W'(1);
      pending_segs.delete();
    end else begin
      if (seg_mon.valid && seg_mon.ready) check_segment();
      if (req_mon.valid && req_mon.ready)
        plan_line_segments(req_mon.req_type, req_mon.level, req_mon.entry_index,
                           req_mon.entry_threshold, req_mon.entry_code);
      if (psel_i && penable_i && pready_i) track_register();
    end
    pending_cnt = pending_segs.size();
  end

endmodule

// File: dv/tb_single_wire_backlight_dimming_core.sv
`timescale 1ns / 1ps
module tb_single_wire_backlight_dimming_core;
  import swbd_pkg::*;

  localparam int ENTRIES       = TABLE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 48;    // longest scan plus output register, with margin
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_WORDS   = 24;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  swbd_in_if  req_if ();
  swbd_out_if seg_if ();

  int fail_count;
  int pending;
  int words_checked;
  int frames;

  // Stimulus bookkeeping
  bit         quiet      = 1'b0;
  int         gap_pct    = 25;
  int         stall_pct  = 25;
  int         stall_left = 0;
  int         idle_cycles = 0;
  int         len_raw    = 1;
  int         words_sent = 0;
  int         table_words = 0;
  int         reg_writes = 0;
  bit         written  [ENTRIES];
  logic [7:0] thr_copy [ENTRIES];

  always #4 clk_i = ~clk_i;

  single_wire_backlight_dimming_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (seg_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swbd_line_checker u_line_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_mon         (req_if),
    .seg_mon         (seg_if),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked),
    .frames_o        (frames)
  );

  // Segment sink: stall bursts of random length
  initial begin
    seg_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        seg_if.ready = 1'b0;
        stall_left--;
      end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        seg_if.ready = 1'b0;
        stall_left   = $urandom_range(0, 4);
      end else begin
        seg_if.ready = 1'b1;
      end
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (seg_if.valid && seg_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d segments owed",
               idle_cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int eff_len();
    if (len_raw < 1) return 1;
    if (len_raw > ENTRIES) return ENTRIES;
    return len_raw;
  endfunction

  // Drive one request word and hold it until taken; returns at a falling edge
  task automatic send_word(input req_type_e rt, input logic [7:0] lvl,
                           input logic [4:0] idx, input logic [7:0] thr,
                           input logic [7:0] code);
    int gap;
    if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_if.valid = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid           = 1'b1;
    req_if.req_type        = rt;
    req_if.level           = lvl;
    req_if.entry_index     = idx;
    req_if.entry_threshold = thr;
    req_if.entry_code      = code;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic write_entry(input logic [4:0] idx, input logic [7:0] thr,
                             input logic [7:0] code);
    send_word(REQ_TABLE, 8'($urandom), idx, thr, code);
    written[idx]  = 1'b1;
    thr_copy[idx] = thr;
    table_words++;
  endtask

  // A nonzero level searches entries below the table length, so those get filled first
  task automatic request_level(input logic [7:0] lvl);
    if (lvl != 8'd0) begin
      for (int i = 0; i < eff_len(); i++) begin
        if (!written[i]) write_entry(5'(i), 8'($urandom), 8'($urandom));
      end
    end
    send_word(REQ_LEVEL, lvl, 5'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Level choice biased toward threshold boundaries of the searched entries
  function automatic logic [7:0] pick_level();
    int k;
    int j;
    k = $urandom_range(0, 9);
    j = $urandom_range(0, eff_len() - 1);
    if (k == 0) return 8'd0;
    if (k < 4 && written[j]) return thr_copy[j];
    if (k < 6 && written[j] && thr_copy[j] != 8'hFF) return thr_copy[j] + 8'd1;
    return 8'($urandom_range(1, 255));
  endfunction

  // Let the core go idle: no word owed and any trailing scan finished
  task automatic settle();
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_access(input reg_idx_e r, input logic wr, input logic [31:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = APB_ADDR_W'(r) << 2;
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Register write with read-back; only called while the core is idle
  task automatic cfg_write(input reg_idx_e r, input logic [31:0] v);
    apb_access(r, 1'b1, v);
    apb_access(r, 1'b0, '0);
    if (r == REG_TABLE_LENGTH) len_raw = int'(v[LEN_REG_W-1:0]);
    reg_writes++;
  endtask

  initial begin
    int lens [7];
    int pick;
    lens = '{63, 2, 33, 5, 32, 1, 8};
    req_if.valid           = 1'b0;
    req_if.req_type        = REQ_LEVEL;
    req_if.level           = '0;
    req_if.entry_index     = '0;
    req_if.entry_threshold = '0;
    req_if.entry_code      = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset registers, off before anything sent, unchanged index after off
    request_level(8'd0);
    write_entry(5'd0, 8'hFF, 8'hA5);
    request_level(8'd255);
    write_entry(5'd31, 8'h00, 8'hFF);
    settle();
    cfg_write(REG_DEVICE_ADDRESS, 32'hFF);
    cfg_write(REG_TABLE_LENGTH, 32'd3);
    write_entry(5'd0, 8'd10, 8'hA5);
    write_entry(5'd1, 8'd20, 8'h00);
    write_entry(5'd2, 8'd100, 8'h5A);
    request_level(8'd15);   // entry 1: frame with code all zeros
    request_level(8'd15);   // same entry: nothing
    request_level(8'd255);  // no threshold reaches: last entry searched
    request_level(8'd100);  // equal to threshold: still entry 2
    request_level(8'd0);
    request_level(8'd1);    // entry 0 right after off: nothing
    request_level(8'd11);
    request_level(8'd10);
    settle();
    // table_length of zero behaves as one
    cfg_write(REG_DEVICE_ADDRESS, 32'h00);
    cfg_write(REG_TABLE_LENGTH, 32'd0);
    request_level(8'd200);
    request_level(8'd0);
    request_level(8'd255);

    // Random phases, each with its own register settings
    for (int p = 0; p < 7; p++) begin
      settle();
      quiet     = (p == 6);
      gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 25;
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      cfg_write(REG_DEVICE_ADDRESS, $urandom_range(0, 255));
      cfg_write(REG_TABLE_LENGTH, lens[p]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) write_entry(5'($urandom), 8'($urandom), 8'($urandom));
        else request_level(pick_level());
      end
    end

    settle();
    $display("Run: %0d request words (%0d table writes), %0d register writes",
             words_sent, table_words, reg_writes);
    $display("Checked %0d segment words in %0d code frames plus off commands",
             words_checked, frames);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d segments never arrived", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/swbd_pkg.sv
hdl/swbd_if.sv
hdl/swbd_table.sv
hdl/single_wire_backlight_dimming_core.sv
hdl/swbd_checker.sv
dv/swbd_line_checker.sv
dv/tb_single_wire_backlight_dimming_core.sv
